>>> src/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bpc_pkg;

  // Field widths
  localparam int RAW_W   = 24;                // raw conversion words
  localparam int CAL_W   = 16;                // calibration words
  localparam int DT_W    = RAW_W + 1;         // signed temperature delta
  localparam int MUL_W   = DT_W + CAL_W + 1;  // delta times calibration word
  localparam int SQ_W    = 2 * RAW_W;         // delta squared (never negative)
  localparam int TEMP_W  = 19;                // temperature in 0.01 degC
  localparam int T2_W    = 17;                // second-order temperature term
  localparam int ACC_W   = 40;                // offset and sensitivity
  localparam int LSQ_W   = 36;                // low-temperature squares
  localparam int PL_W    = RAW_W + 20;        // low partial product
  localparam int PH_W    = RAW_W + 21;        // high partial product
  localparam int PROD_W  = 64;                // D1 * SENS
  localparam int X_W     = 44;                // scaled product minus offset
  localparam int PRESS_W = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int IDX_W   = 3;

  // Scaling shifts
  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int PS_SHIFT   = 21;
  localparam int PF_SHIFT   = 15;

  // Temperature thresholds, 0.01 degC
  localparam int TEMP_REF = 2000;
  localparam int LOW_TEMP = -1500;

  // Rounding biases for signed divide-toward-zero by a power of two
  localparam logic signed [MUL_W-1:0] TEMP_BIAS =
    MUL_W'((64'sd1 <<< TEMP_SHIFT) - 64'sd1);
  localparam logic signed [MUL_W-1:0] OFF_BIAS =
    MUL_W'((64'sd1 <<< OFF_SHIFT) - 64'sd1);
  localparam logic signed [MUL_W-1:0] SENS_BIAS =
    MUL_W'((64'sd1 <<< SENS_SHIFT) - 64'sd1);
  localparam logic signed [PROD_W-1:0] PS_BIAS =
    PROD_W'((64'sd1 <<< PS_SHIFT) - 64'sd1);
  localparam logic signed [X_W-1:0] PF_BIAS =
    X_W'((64'sd1 <<< PF_SHIFT) - 64'sd1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SENS_BASE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_BASE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
  localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_COEFF    = 3'd5;
  localparam logic [IDX_W-1:0] REG_SO_ENABLE     = 3'd6;

  typedef struct packed {
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] offset_base;
    logic [CAL_W-1:0] sens_tempco;
    logic [CAL_W-1:0] offset_tempco;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_coeff;
    logic             so_en;
  } cal_t;

  // First-order results
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
    logic        [T2_W-1:0]   temp2;
  } first_t;

  // Corrected terms
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [ACC_W-1:0]  off;
    logic signed [ACC_W-1:0]  sens;
    logic signed [TEMP_W-1:0] temp;
  } corr_t;

  typedef struct packed {
    logic signed [PRESS_W-1:0] pressure;
    logic signed [TEMP_W-1:0]  temperature;
  } res_t;

endpackage

>>> src/bpc_front.sv
// First-order terms: delta temperature, calibration products, TEMP/OFF/SENS.
module bpc_front import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic [RAW_W-1:0]      d1,
  input  logic [RAW_W-1:0]      d2,
  input  cal_t                  cal,
  output logic                  out_valid,
  output first_t                out_data
);

  // stage 1: delta
  logic                    v1_r;
  logic [RAW_W-1:0]        d1_1_r;
  logic signed [DT_W-1:0]  dt1_r, dt1_nxt;
  // stage 2: products
  logic                    v2_r;
  logic [RAW_W-1:0]        d1_2_r;
  logic signed [MUL_W-1:0] pt2_r, po2_r, ps2_r, pt2_nxt, po2_nxt, ps2_nxt;
  logic [SQ_W-1:0]         sq2_r, sq2_nxt;
  // stage 3: scaled sums
  logic                    v3_r;
  first_t                  s3_r, s3_nxt;

  always_comb begin
    dt1_nxt = $signed({1'b0, d2}) - $signed({1'b0, cal.ref_temp, 8'b0});
  end

  always_comb begin
    logic signed [2*DT_W-1:0] sq;
    sq      = dt1_r * dt1_r;
    pt2_nxt = dt1_r * $signed({1'b0, cal.temp_coeff});
    po2_nxt = dt1_r * $signed({1'b0, cal.offset_tempco});
    ps2_nxt = dt1_r * $signed({1'b0, cal.sens_tempco});
    sq2_nxt = SQ_W'(sq);
  end

  always_comb begin
    logic signed [MUL_W-1:0] bt, bo, bs, qt, qo, qs;
    bt = '0;
    bo = '0;
    bs = '0;
    if (pt2_r[MUL_W-1]) bt = TEMP_BIAS;
    if (po2_r[MUL_W-1]) bo = OFF_BIAS;
    if (ps2_r[MUL_W-1]) bs = SENS_BIAS;
    qt = (pt2_r + bt) >>> TEMP_SHIFT;
    qo = (po2_r + bo) >>> OFF_SHIFT;
    qs = (ps2_r + bs) >>> SENS_SHIFT;
    s3_nxt.d1    = d1_2_r;
    s3_nxt.temp  = TEMP_W'(qt + MUL_W'(TEMP_REF));
    s3_nxt.off   = ACC_W'($signed({1'b0, cal.offset_base, 16'b0})) + ACC_W'(qo);
    s3_nxt.sens  = ACC_W'($signed({1'b0, cal.sens_base, 15'b0})) + ACC_W'(qs);
    s3_nxt.temp2 = T2_W'(sq2_r >> T2_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (in_valid) begin
        d1_1_r <= d1;
        dt1_r  <= dt1_nxt;
      end
      if (v1_r) begin
        d1_2_r <= d1_1_r;
        pt2_r  <= pt2_nxt;
        po2_r  <= po2_nxt;
        ps2_r  <= ps2_nxt;
        sq2_r  <= sq2_nxt;
      end
      if (v2_r) begin
        s3_r <= s3_nxt;
      end
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

>>> src/bpc_corr.sv
// Low-temperature second-order correction of TEMP, OFF and SENS.
module bpc_corr import bpc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   ce,
  input  logic   so_en,
  input  logic   in_valid,
  input  first_t in_data,
  output logic   out_valid,
  output corr_t  out_data
);

  // stage 4: squares and flags
  logic             v4_r;
  first_t           s4_r;
  logic             act4_r, cold4_r, act4_nxt, cold4_nxt;
  logic [LSQ_W-1:0] lo4_r, vlo4_r, lo4_nxt, vlo4_nxt;
  // stage 5: corrected terms
  logic             v5_r;
  corr_t            s5_r, s5_nxt;

  always_comb begin
    logic signed [TEMP_W:0]     tm, tp;
    logic signed [2*TEMP_W+1:0] sq_lo, sq_vlo;
    tm        = (TEMP_W+1)'(in_data.temp) - (TEMP_W+1)'(TEMP_REF);
    tp        = (TEMP_W+1)'(in_data.temp) - (TEMP_W+1)'(LOW_TEMP);
    sq_lo     = tm * tm;
    sq_vlo    = tp * tp;
    lo4_nxt   = LSQ_W'(sq_lo);
    vlo4_nxt  = LSQ_W'(sq_vlo);
    act4_nxt  = so_en && (in_data.temp < TEMP_W'(TEMP_REF));
    cold4_nxt = in_data.temp < TEMP_W'(LOW_TEMP);
  end

  always_comb begin
    logic [ACC_W-1:0]      lo_e, vlo_e, five_lo, seven_vlo, eleven_vlo, off2, sens2;
    logic [T2_W-1:0]       t2;
    logic signed [TEMP_W:0] tdiff;
    lo_e       = ACC_W'(lo4_r);
    vlo_e      = ACC_W'(vlo4_r);
    five_lo    = (lo_e << 2) + lo_e;
    seven_vlo  = (vlo_e << 3) - vlo_e;
    eleven_vlo = (vlo_e << 3) + (vlo_e << 1) + vlo_e;
    off2       = '0;
    sens2      = '0;
    t2         = '0;
    if (act4_r) begin
      t2    = s4_r.temp2;
      off2  = five_lo >> 1;
      sens2 = five_lo >> 2;
      if (cold4_r) begin
        off2  = off2 + seven_vlo;
        sens2 = sens2 + (eleven_vlo >> 1);
      end
    end
    tdiff       = (TEMP_W+1)'(s4_r.temp) - $signed({3'b0, t2});
    s5_nxt.d1   = s4_r.d1;
    s5_nxt.off  = s4_r.off - $signed(off2);
    s5_nxt.sens = s4_r.sens - $signed(sens2);
    s5_nxt.temp = TEMP_W'(tdiff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (ce) begin
      v4_r <= in_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (in_valid) begin
        s4_r    <= in_data;
        act4_r  <= act4_nxt;
        cold4_r <= cold4_nxt;
        lo4_r   <= lo4_nxt;
        vlo4_r  <= vlo4_nxt;
      end
      if (v4_r) begin
        s5_r <= s5_nxt;
      end
    end
  end

  assign out_valid = v5_r;
  assign out_data  = s5_r;

endmodule

>>> src/bpc_press.sv
// Pressure: split D1*SENS multiply, scale, subtract offset, final scale.
module bpc_press import bpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  ce,
  input  logic  in_valid,
  input  corr_t in_data,
  output logic  out_valid,
  output res_t  out_data
);

  // stage 6: partial products
  logic                     v6_r;
  logic [PL_W-1:0]          pl6_r, pl6_nxt;
  logic signed [PH_W-1:0]   ph6_r, ph6_nxt;
  logic signed [ACC_W-1:0]  off6_r;
  logic signed [TEMP_W-1:0] t6_r;
  // stage 7: full product
  logic                     v7_r;
  logic signed [PROD_W-1:0] prod7_r, prod7_nxt;
  logic signed [ACC_W-1:0]  off7_r;
  logic signed [TEMP_W-1:0] t7_r;
  // stage 8: scaled product minus offset
  logic                     v8_r;
  logic signed [X_W-1:0]    x8_r, x8_nxt;
  logic signed [TEMP_W-1:0] t8_r;
  // stage 9: result
  logic                     v9_r;
  res_t                     res9_r, res9_nxt;

  always_comb begin
    pl6_nxt = in_data.d1 * in_data.sens[19:0];
    ph6_nxt = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[ACC_W-1:20]);
  end

  always_comb begin
    prod7_nxt = (PROD_W'(ph6_r) <<< 20) + $signed({20'b0, pl6_r});
  end

  always_comb begin
    logic signed [PROD_W-1:0] b, q;
    b = '0;
    if (prod7_r[PROD_W-1]) b = PS_BIAS;
    q      = (prod7_r + b) >>> PS_SHIFT;
    x8_nxt = X_W'(q) - X_W'(off7_r);
  end

  always_comb begin
    logic signed [X_W-1:0] b, q;
    b = '0;
    if (x8_r[X_W-1]) b = PF_BIAS;
    q                    = (x8_r + b) >>> PF_SHIFT;
    res9_nxt.pressure    = PRESS_W'(q);
    res9_nxt.temperature = t8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (ce) begin
      v6_r <= in_valid;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (in_valid) begin
        pl6_r  <= pl6_nxt;
        ph6_r  <= ph6_nxt;
        off6_r <= in_data.off;
        t6_r   <= in_data.temp;
      end
      if (v6_r) begin
        prod7_r <= prod7_nxt;
        off7_r  <= off6_r;
        t7_r    <= t6_r;
      end
      if (v7_r) begin
        x8_r <= x8_nxt;
        t8_r <= t7_r;
      end
      if (v8_r) begin
        res9_r <= res9_nxt;
      end
    end
  end

  assign out_valid = v9_r;
  assign out_data  = res9_r;

endmodule

>>> src/bpc_skid.sv
// Output register with one skid entry; its ready drives the pipeline enable.
module bpc_skid import bpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic sk_valid_r, sk_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t sk_data_r, sk_data_nxt;
  logic push, pop;

  assign in_ready = !sk_valid_r;
  assign push     = in_valid && !sk_valid_r;
  assign pop      = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    out_data_nxt  = out_data_r;
    sk_data_nxt   = sk_data_r;
    if (sk_valid_r) begin
      if (pop) begin
        out_data_nxt = sk_data_r;
        sk_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        sk_data_nxt  = in_data;
        sk_valid_nxt = 1'b1;
      end else begin
        out_data_nxt  = in_data;
        out_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sk_data_r  <= sk_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/baro_pressure_temp_compensation_top.sv
// Top level: barometric pressure and temperature compensation pipeline.
//
// Usage
//  - Input stream: one transfer carries a raw pressure word (D1) and a raw
//    temperature word (D2). Output stream: one transfer per input transfer
//    with compensated pressure (0.01 mbar, low 32 bits) and temperature
//    (0.01 degC), in input order.
//  - Config port: write calibration words C1..C6 at indexes 0..5 and the
//    second-order enable at index 6 while the stream is idle. Index 7 is
//    ignored. Writes take effect at the clock edge; no read-back.
//  - Pipeline: ten register stages (nine pipeline stages, the first loaded at
//    the input transfer edge, plus the output register). out_tvalid rises
//    when a result loads into the output register, and the earliest output
//    transfer is in that cycle when the receiver is not stalling.
//  - Throughput: one transfer per cycle unless stalled. The slowest stages
//    hold a 25x25 square beside three 25x17 multiplies, or one 64-bit add
//    and shift; the D1*SENS product is split into 24x20 and 25x20 partial
//    products joined one stage later.
//  - Reset (rst_n low, synchronous): pipeline and output valid bits clear,
//    calibration words go to 0 and the second-order enable to 1.
//  - Stall: when out_tready is low one more result is caught in a skid
//    entry; once it is full the whole pipeline freezes and in_tready drops.
//    in_tready comes straight from a register.
module baro_pressure_temp_compensation_top import bpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] pressure, [50:32] temperature, rest 0
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CAL_W-1:0]       cfg_wdata
);

  cal_t   cal_r, cal_nxt;
  logic   pipe_ce;
  logic   v_front, v_corr, v_press;
  first_t front_data;
  corr_t  corr_data;
  res_t   press_data, out_data;

  // Calibration register file
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SENS_BASE:     cal_nxt.sens_base     = cfg_wdata;
        REG_OFFSET_BASE:   cal_nxt.offset_base   = cfg_wdata;
        REG_SENS_TEMPCO:   cal_nxt.sens_tempco   = cfg_wdata;
        REG_OFFSET_TEMPCO: cal_nxt.offset_tempco = cfg_wdata;
        REG_REF_TEMP:      cal_nxt.ref_temp      = cfg_wdata;
        REG_TEMP_COEFF:    cal_nxt.temp_coeff    = cfg_wdata;
        REG_SO_ENABLE:     cal_nxt.so_en         = cfg_wdata[0];
        default:           cal_nxt = cal_r;  // index past the list: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all words zero, second-order enable (lowest bit) set
      cal_r <= cal_t'({{($bits(cal_t)-1){1'b0}}, 1'b1});
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // Whole pipeline advances together; held only while the skid entry is full
  assign in_tready = pipe_ce;

  bpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (pipe_ce),
    .in_valid  (in_tvalid),
    .d1        (in_tdata[RAW_W-1:0]),
    .d2        (in_tdata[2*RAW_W-1:RAW_W]),
    .cal       (cal_r),
    .out_valid (v_front),
    .out_data  (front_data)
  );

  bpc_corr u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (pipe_ce),
    .so_en     (cal_r.so_en),
    .in_valid  (v_front),
    .in_data   (front_data),
    .out_valid (v_corr),
    .out_data  (corr_data)
  );

  bpc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (pipe_ce),
    .in_valid  (v_corr),
    .in_data   (corr_data),
    .out_valid (v_press),
    .out_data  (press_data)
  );

  bpc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_press),
    .in_ready  (pipe_ce),
    .in_data   (press_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {{(OUT_TDATA_W - PRESS_W - TEMP_W){1'b0}},
                      out_data.temperature, out_data.pressure};

  // Frozen pipeline keeps every in-flight item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_ce |=> $stable({v_front, v_corr, v_press}))
    else $error("pipeline valid bits changed during stall");

  // Skid entry only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("skid entry full with empty output register");

  // Skid fills only when the receiver held off a waiting result
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("skid filled without output stall");

endmodule
